### design/bfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the bird fractal escape-time unit.
// Used by every module of the block; depends on nothing.
package bfe_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int COORD_BITS  = 12;
   localparam int WORD_W      = 32;
   localparam int WIDE_W      = 66;
   localparam int IDX_W       = 12;
   localparam int STEP_W      = 31;
   localparam int ITER_W      = 12;
   localparam int PROD_W      = COORD_BITS + STEP_W;
   localparam int MUL_W       = 2 * WORD_W;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_RE_ORIGIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RE_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IM_ORIGIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IM_STEP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [WORD_W-2:0] mag_type;

   typedef struct packed {
      word_type c_re;
      word_type c_im;
   } coord_type;

   // Clamps a wide signed value to the signed word range.
   function automatic word_type sat_word(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-WORD_W:0] top;
      top = v[WIDE_W-1:WORD_W-1];
      if (top == '0 || top == '1) begin
         sat_word = v[WORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         sat_word = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat_word = {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

   // Absolute value; the most negative word maps to the largest word.
   function automatic mag_type abs_sat(input word_type x);
      word_type neg;
      neg = -x;
      if (!x[WORD_W-1]) begin
         abs_sat = x[WORD_W-2:0];
      end else if (x == {1'b1, {(WORD_W-1){1'b0}}}) begin
         abs_sat = '1;
      end else begin
         abs_sat = neg[WORD_W-2:0];
      end
   endfunction

endpackage

### design/bfe_front.sv
`timescale 1ns / 1ps
// Front end: takes pixel indexes and maps them to the complex point c in two stages.
// Uses bfe_pkg; pushes finished points into bfe_queue.
module bfe_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bfe_pkg::IDX_W-1:0]     req_col,
   input  logic [bfe_pkg::IDX_W-1:0]     req_row,
   input  bfe_pkg::word_type             re_origin,
   input  logic [bfe_pkg::STEP_W-1:0]    re_step,
   input  bfe_pkg::word_type             im_origin,
   input  logic [bfe_pkg::STEP_W-1:0]    im_step,
   input  logic [bfe_pkg::QCNT_W-1:0]    q_count,
   output logic                          push,
   output bfe_pkg::coord_type            push_data
);

   logic                             p_valid_ff, p_valid_in;
   logic [bfe_pkg::PROD_W-1:0]       re_prod_ff, re_prod_in;
   logic [bfe_pkg::PROD_W-1:0]       im_prod_ff, im_prod_in;
   logic [bfe_pkg::QCNT_W:0]         pending;
   logic                             accept;
   logic signed [bfe_pkg::WIDE_W-1:0] re_sum, im_sum;

   assign pending = {1'b0, q_count} + {{bfe_pkg::QCNT_W{1'b0}}, p_valid_ff};
   assign busy    = pending >= (bfe_pkg::QCNT_W + 1)'(bfe_pkg::QUEUE_DEPTH);
   assign accept  = start && !busy;

   always_comb begin
      p_valid_in = accept;
      re_prod_in = bfe_pkg::PROD_W'(req_col[bfe_pkg::COORD_BITS-1:0])
                   * bfe_pkg::PROD_W'(re_step);
      im_prod_in = bfe_pkg::PROD_W'(req_row[bfe_pkg::COORD_BITS-1:0])
                   * bfe_pkg::PROD_W'(im_step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
      re_prod_ff <= re_prod_in;
      im_prod_ff <= im_prod_in;
   end

   always_comb begin
      re_sum = bfe_pkg::WIDE_W'(re_origin)
               + $signed({{(bfe_pkg::WIDE_W-bfe_pkg::PROD_W){1'b0}}, re_prod_ff});
      im_sum = bfe_pkg::WIDE_W'(im_origin)
               + $signed({{(bfe_pkg::WIDE_W-bfe_pkg::PROD_W){1'b0}}, im_prod_ff});
      push_data.c_re = bfe_pkg::sat_word(re_sum);
      push_data.c_im = bfe_pkg::sat_word(im_sum);
   end

   assign push = p_valid_ff;

endmodule

### design/bfe_queue.sv
`timescale 1ns / 1ps
// Short queue of mapped points between the front end and the iteration engine.
// Uses bfe_pkg for the entry type and depth.
module bfe_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bfe_pkg::coord_type            push_data,
   input  logic                          pop,
   output bfe_pkg::coord_type            pop_data,
   output logic [bfe_pkg::QCNT_W-1:0]    count
);

   bfe_pkg::coord_type             mem_ff [bfe_pkg::QUEUE_DEPTH];
   logic [bfe_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [bfe_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [bfe_pkg::QCNT_W-1:0]     count_ff, count_in;

   function automatic logic [bfe_pkg::PTR_W-1:0] next_ptr(input logic [bfe_pkg::PTR_W-1:0] p);
      if (p == bfe_pkg::PTR_W'(bfe_pkg::QUEUE_DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = p + 1'b1;
      end
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

### design/bfe_back.sv
`timescale 1ns / 1ps
// Iteration engine: runs the bird-of-prey recurrence on one point at a time.
// Uses bfe_pkg; takes points from bfe_queue and drives the result strobe.
module bfe_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bfe_pkg::QCNT_W-1:0]    q_count,
   input  bfe_pkg::coord_type            q_data,
   output logic                          pop,
   input  logic [bfe_pkg::ITER_W-1:0]    max_iter,
   input  logic [bfe_pkg::STEP_W-1:0]    escape_limit,
   output logic                          rsp_valid,
   output logic [bfe_pkg::ITER_W-1:0]    rsp_iter_count
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_SQ    = 3'd4;
   localparam logic [2:0] ST_SQSAT = 3'd5;

   logic [2:0]                           state_ff, state_in;
   bfe_pkg::coord_type                   c_ff, c_in;
   bfe_pkg::word_type                    x_ff, x_in, y_ff, y_in;
   bfe_pkg::mag_type                     x2_ff, x2_in, y2_ff, y2_in;
   bfe_pkg::mag_type                     ax_ff, ax_in, ay_ff, ay_in;
   bfe_pkg::word_type                    tre_ff, tre_in, tim_ff, tim_in;
   logic signed [bfe_pkg::MUL_W-1:0]     pa_ff, pa_in, pb_ff, pb_in;
   logic [bfe_pkg::ITER_W-1:0]           k_ff, k_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [bfe_pkg::ITER_W-1:0]           iter_ff, iter_in;
   logic signed [bfe_pkg::WIDE_W-1:0]    x2w, y2w;
   logic [bfe_pkg::WORD_W-1:0]           mag_sum;
   logic                                 escaped;
   bfe_pkg::word_type                    mra, mrb, sqa, sqb;

   always_comb begin
      x2w     = $signed(bfe_pkg::WIDE_W'(x2_ff));
      y2w     = $signed(bfe_pkg::WIDE_W'(y2_ff));
      mag_sum = {1'b0, x2_ff} + {1'b0, y2_ff};
      escaped = mag_sum > {1'b0, escape_limit};
      mra     = bfe_pkg::sat_word(bfe_pkg::WIDE_W'(pa_ff >>> bfe_pkg::FRAC_BITS));
      mrb     = bfe_pkg::sat_word(bfe_pkg::WIDE_W'(pb_ff >>> bfe_pkg::FRAC_BITS));
      sqa     = mra;
      sqb     = mrb;

      state_in     = state_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      tre_in       = tre_ff;
      tim_in       = tim_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      iter_in      = iter_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_count != '0) begin
               pop      = 1'b1;
               c_in     = q_data;
               x_in     = '0;
               y_in     = '0;
               x2_in    = '0;
               y2_in    = '0;
               k_in     = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (k_ff >= max_iter || escaped) begin
               rsp_valid_in = 1'b1;
               iter_in      = k_ff;
               state_in     = ST_IDLE;
            end else begin
               tre_in   = bfe_pkg::sat_word(x2w - (y2w + (y2w <<< 1)));
               tim_in   = bfe_pkg::sat_word((x2w + (x2w <<< 1)) - y2w);
               ax_in    = bfe_pkg::abs_sat(x_ff);
               ay_in    = bfe_pkg::abs_sat(y_ff);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pa_in    = bfe_pkg::MUL_W'($signed({1'b0, ax_ff})) * bfe_pkg::MUL_W'(tre_ff);
            pb_in    = bfe_pkg::MUL_W'($signed({1'b0, ay_ff})) * bfe_pkg::MUL_W'(tim_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            x_in     = bfe_pkg::sat_word(bfe_pkg::WIDE_W'(mra) + bfe_pkg::WIDE_W'(c_ff.c_re));
            y_in     = bfe_pkg::sat_word(bfe_pkg::WIDE_W'(mrb) + bfe_pkg::WIDE_W'(c_ff.c_im));
            state_in = ST_SQ;
         end
         ST_SQ: begin
            pa_in    = bfe_pkg::MUL_W'(x_ff) * bfe_pkg::MUL_W'(x_ff);
            pb_in    = bfe_pkg::MUL_W'(y_ff) * bfe_pkg::MUL_W'(y_ff);
            state_in = ST_SQSAT;
         end
         ST_SQSAT: begin
            x2_in    = sqa[bfe_pkg::WORD_W-2:0];
            y2_in    = sqb[bfe_pkg::WORD_W-2:0];
            k_in     = k_ff + 1'b1;
            state_in = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff    <= c_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      x2_ff   <= x2_in;
      y2_ff   <= y2_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      tre_ff  <= tre_in;
      tim_ff  <= tim_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      k_ff    <= k_in;
      iter_ff <= iter_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = iter_ff;

endmodule

### design/bird_fractal_escape_time_unit.sv
`timescale 1ns / 1ps
// Top level of the bird fractal escape-time unit: control registers and block wiring.
// Depends on bfe_pkg, bfe_front, bfe_queue and bfe_back.
//
// A pixel (req_col, req_row) is taken as a beat at a rising edge with start high and
// busy low. The front end maps it to the point c through a registered product and
// places it in a two-entry queue, so up to two pixels can be waiting while one iterates.
// The iteration engine loads a point in ST_IDLE, runs each iteration through ST_CHECK,
// ST_MUL, ST_ADD, ST_SQ and ST_SQSAT (two multiplier passes, each followed by a
// register), and ends with a final test in ST_CHECK. It takes a new point from the
// queue only after it has returned to ST_IDLE. The result is driven on rsp_iter_count
// for exactly one cycle with rsp_valid high; the receiver cannot stall it.
// Results leave in the order taken.
// Control registers are written through csr_valid/csr_ready (always ready), by
// index on csr_index; unknown indexes are ignored. Write them only while idle.
// A synchronous reset empties the queue, idles the engine and restores the
// register defaults; no clearing pass is needed.
module bird_fractal_escape_time_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bfe_pkg::IDX_W-1:0]        req_col,
   input  logic [bfe_pkg::IDX_W-1:0]        req_row,
   output logic                             rsp_valid,
   output logic [bfe_pkg::ITER_W-1:0]       rsp_iter_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfe_pkg::WORD_W-1:0]       csr_wdata
);

   bfe_pkg::word_type              re_origin_ff, re_origin_in;
   logic [bfe_pkg::STEP_W-1:0]     re_step_ff, re_step_in;
   bfe_pkg::word_type              im_origin_ff, im_origin_in;
   logic [bfe_pkg::STEP_W-1:0]     im_step_ff, im_step_in;
   logic [bfe_pkg::ITER_W-1:0]     max_iter_ff, max_iter_in;
   logic [bfe_pkg::STEP_W-1:0]     escape_limit_ff, escape_limit_in;

   logic                           push, pop;
   bfe_pkg::coord_type             push_data, pop_data;
   logic [bfe_pkg::QCNT_W-1:0]     q_count;

   assign csr_ready = 1'b1;

   always_comb begin
      re_origin_in    = re_origin_ff;
      re_step_in      = re_step_ff;
      im_origin_in    = im_origin_ff;
      im_step_in      = im_step_ff;
      max_iter_in     = max_iter_ff;
      escape_limit_in = escape_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bfe_pkg::REG_RE_ORIGIN:    re_origin_in    = csr_wdata;
            bfe_pkg::REG_RE_STEP:      re_step_in      = csr_wdata[bfe_pkg::STEP_W-1:0];
            bfe_pkg::REG_IM_ORIGIN:    im_origin_in    = csr_wdata;
            bfe_pkg::REG_IM_STEP:      im_step_in      = csr_wdata[bfe_pkg::STEP_W-1:0];
            bfe_pkg::REG_MAX_ITER:     max_iter_in     = csr_wdata[bfe_pkg::ITER_W-1:0];
            bfe_pkg::REG_ESCAPE_LIMIT: escape_limit_in = csr_wdata[bfe_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         re_origin_ff    <= -32'sd536870912;
         re_step_ff      <= 31'd1048576;
         im_origin_ff    <= -32'sd536870912;
         im_step_ff      <= 31'd1048576;
         max_iter_ff     <= 12'd50;
         escape_limit_ff <= 31'd1073741824;
      end else begin
         re_origin_ff    <= re_origin_in;
         re_step_ff      <= re_step_in;
         im_origin_ff    <= im_origin_in;
         im_step_ff      <= im_step_in;
         max_iter_ff     <= max_iter_in;
         escape_limit_ff <= escape_limit_in;
      end
   end

   bfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_col   (req_col),
      .req_row   (req_row),
      .re_origin (re_origin_ff),
      .re_step   (re_step_ff),
      .im_origin (im_origin_ff),
      .im_step   (im_step_ff),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   bfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   bfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_count        (q_count),
      .q_data         (pop_data),
      .pop            (pop),
      .max_iter       (max_iter_ff),
      .escape_limit   (escape_limit_ff),
      .rsp_valid      (rsp_valid),
      .rsp_iter_count (rsp_iter_count)
   );

endmodule

### tb/bfe_escape_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bird fractal escape-time unit: mirrors the control registers,
// predicts the iteration count of every accepted pixel beat and checks each result beat.
// Depends on bfe_pkg for widths and register indexes.
module bfe_escape_checker
   import bfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [IDX_W-1:0]     req_col,
   input  logic [IDX_W-1:0]     req_row,
   input  logic                 rsp_valid,
   input  logic [ITER_W-1:0]    rsp_iter_count,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output int                   mismatches,
   output int                   outstanding
);

   localparam longint WORD_HI = 2147483647;
   localparam longint WORD_LO = -WORD_HI - 1;

   localparam longint DEF_RE_ORIGIN    = -536870912;
   localparam longint DEF_RE_STEP      = 1048576;
   localparam longint DEF_IM_ORIGIN    = -536870912;
   localparam longint DEF_IM_STEP      = 1048576;
   localparam int     DEF_MAX_ITER     = 50;
   localparam longint DEF_ESCAPE_LIMIT = 1073741824;

   longint re_origin_q    = DEF_RE_ORIGIN;
   longint re_step_q      = DEF_RE_STEP;
   longint im_origin_q    = DEF_IM_ORIGIN;
   longint im_step_q      = DEF_IM_STEP;
   int     max_iter_q     = DEF_MAX_ITER;
   longint escape_limit_q = DEF_ESCAPE_LIMIT;

   logic [ITER_W-1:0] expected_counts[$];
   logic [ITER_W-1:0] oldest;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // The arithmetic shift rounds toward minus infinity, as the datapath does.
   function automatic longint fx_product(input longint a, input longint b);
      return clamp_word((a * b) >>> FRAC_BITS);
   endfunction

   function automatic longint magnitude(input longint a);
      return clamp_word(a < 0 ? -a : a);
   endfunction

   function automatic longint pixel_coord(input longint origin, input longint step,
                                          input logic [IDX_W-1:0] idx);
      longint masked;
      masked = longint'(idx) & ((longint'(1) << COORD_BITS) - 1);
      return clamp_word(origin + masked * step);
   endfunction

   function automatic logic [ITER_W-1:0] escape_iterations(input logic [IDX_W-1:0] col,
                                                           input logic [IDX_W-1:0] row);
      longint c_re, c_im, x, y, x2, y2, t_re, t_im;
      int     k;
      c_re = pixel_coord(re_origin_q, re_step_q, col);
      c_im = pixel_coord(im_origin_q, im_step_q, row);
      x = 0;
      y = 0;
      x2 = 0;
      y2 = 0;
      k = 0;
      while (k < max_iter_q) begin
         if (x2 + y2 > escape_limit_q) break;
         t_re = clamp_word(x2 - 3 * y2);
         t_im = clamp_word(3 * x2 - y2);
         x = clamp_word(fx_product(magnitude(x), t_re) + c_re);
         y = clamp_word(fx_product(magnitude(y), t_im) + c_im);
         x2 = fx_product(x, x);
         y2 = fx_product(y, y);
         k++;
      end
      return ITER_W'(k);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_counts.delete();
         re_origin_q    = DEF_RE_ORIGIN;
         re_step_q      = DEF_RE_STEP;
         im_origin_q    = DEF_IM_ORIGIN;
         im_step_q      = DEF_IM_STEP;
         max_iter_q     = DEF_MAX_ITER;
         escape_limit_q = DEF_ESCAPE_LIMIT;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RE_ORIGIN:    re_origin_q    = longint'($signed(csr_wdata));
               REG_RE_STEP:      re_step_q      = longint'(csr_wdata[STEP_W-1:0]);
               REG_IM_ORIGIN:    im_origin_q    = longint'($signed(csr_wdata));
               REG_IM_STEP:      im_step_q      = longint'(csr_wdata[STEP_W-1:0]);
               REG_MAX_ITER:     max_iter_q     = int'(csr_wdata[ITER_W-1:0]);
               REG_ESCAPE_LIMIT: escape_limit_q = longint'(csr_wdata[STEP_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_counts.size() == 0) begin
               $error("iter_count: result beat with no pixel pending, expected none, actual %0d",
                      rsp_iter_count);
               mismatches++;
            end else begin
               oldest = expected_counts.pop_front();
               if (rsp_iter_count !== oldest) begin
                  $error("iter_count mismatch: expected %0d, actual %0d", oldest, rsp_iter_count);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            expected_counts.push_back(escape_iterations(req_col, req_row));
         end
      end
      outstanding = expected_counts.size();
   end

endmodule

### tb/tb_bird_fractal_escape_time_unit.sv
`timescale 1ns / 1ps
// Top of the escape-time unit testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on bfe_pkg, bird_fractal_escape_time_unit and bfe_escape_checker.
module tb_bird_fractal_escape_time_unit;
   import bfe_pkg::*;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_PIXELS   = 72;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [IDX_W-1:0]     req_col = '0;
   logic [IDX_W-1:0]     req_row = '0;
   logic                 rsp_valid;
   logic [ITER_W-1:0]    rsp_iter_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   int mismatches;
   int outstanding;
   int idle_cycles  = 0;
   int no_idle_left = 0;

   always #5 clock = ~clock;

   bird_fractal_escape_time_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_iter_count (rsp_iter_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   bfe_escape_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_iter_count (rsp_iter_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
      int gap;
      if (no_idle_left > 0) begin
         gap = 0;
         no_idle_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         no_idle_left = $urandom_range(5, 30);
      end else begin
         gap = $urandom_range(0, 17);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start   <= 1'b1;
      req_col <= col;
      req_row <= row;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [WORD_W-1:0] re_org, input logic [WORD_W-1:0] re_stp,
                                 input logic [WORD_W-1:0] im_org, input logic [WORD_W-1:0] im_stp,
                                 input logic [WORD_W-1:0] iters, input logic [WORD_W-1:0] limit);
      logic [CSR_IDX_W-1:0] slot [7];
      logic [WORD_W-1:0]    value [7];
      slot[0] = REG_ESCAPE_LIMIT + CSR_IDX_W'(1 + $urandom_range(0, 1));
      value[0] = $urandom;
      slot[1] = REG_RE_ORIGIN;
      value[1] = re_org;
      slot[2] = REG_RE_STEP;
      value[2] = re_stp;
      slot[3] = REG_IM_ORIGIN;
      value[3] = im_org;
      slot[4] = REG_IM_STEP;
      value[4] = im_stp;
      slot[5] = REG_MAX_ITER;
      value[5] = iters;
      slot[6] = REG_ESCAPE_LIMIT;
      value[6] = limit;
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= slot[i];
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int                style;
      logic [WORD_W-1:0] re_org, re_stp, im_org, im_stp, iters, limit;
      style = $urandom_range(0, 3);
      re_org = WORD_W'(-(5 << 27) + int'($urandom_range(0, 3 << 28)));
      im_org = WORD_W'(-(5 << 27) + int'($urandom_range(0, 3 << 28)));
      re_stp = $urandom_range(1 << 14, 1 << 18);
      im_stp = $urandom_range(1 << 14, 1 << 18);
      iters = $urandom_range(1, 60);
      limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF) : (4 << FRAC_BITS);
      case (style)
         2: begin
            re_org = $urandom;
            re_stp = $urandom;
            im_org = $urandom;
            im_stp = $urandom;
            iters = $urandom_range(0, 24);
            limit = $urandom;
         end
         3: begin
            iters = $urandom_range(0, 40);
            limit = $urandom_range(0, 3);
         end
         default: ;
      endcase
      apply_settings(re_org, re_stp, im_org, im_stp, iters, limit);
      repeat (count) begin
         send_pixel(IDX_W'($urandom), IDX_W'($urandom));
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Power-on register values, index extremes and a walking one against a walking zero.
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd512, 12'd512);
      send_pixel(12'd256, 12'd512);
      send_pixel(12'd2048, 12'd2048);
      for (int b = 0; b < IDX_W; b++) begin
         send_pixel(IDX_W'(1) << b, ~(IDX_W'(1) << b));
      end
      wait_drained();

      // Coordinates that overflow the word range upward, and the most negative imaginary origin.
      apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd5,
                     32'h7FFF_FFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1, 12'd0);
      send_pixel(12'd0, 12'd1);
      wait_drained();

      // A zero iteration cap.
      apply_settings('0, '0, '0, '0, '0, '0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      wait_drained();

      // The real part alternates with the most negative word, so its magnitude saturates,
      // and the orbit never leaves the widest bound before the largest cap.
      apply_settings(32'h8000_0000, '0, '0, '0, 32'd4095, 32'h7FFF_FFFF);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      wait_drained();

      repeat (RANDOM_PHASES) random_phase(PHASE_PIXELS);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
